### sv/tmps_pkg.sv
// Package for the thumb motion phase sequencer: phase, opcode and table codes,
// the pose row type and the widths shared by the interfaces and the top level.
// Depends on nothing.
`default_nettype none

package tmps_pkg;

   localparam int MaxPoses     = 8;
   localparam int PoseFields   = 8;
   localparam int PosBits      = 16;
   localparam int PoseIdxBits  = $clog2(MaxPoses);
   localparam int RevDepth     = MaxPoses * MaxPoses;
   localparam int RevIdxBits   = $clog2(RevDepth);
   localparam int FracBits     = 17;
   localparam int TickBits     = 24;
   localparam int TolBits      = 15;
   localparam int CsrIdxBits   = 3;
   localparam int CsrDataBits  = 24;

   typedef logic [3:0] phase_type;

   localparam phase_type PH_IDLE       = 4'd0;
   localparam phase_type PH_FLEX_CLEAR = 4'd1;
   localparam phase_type PH_ABD_REV    = 4'd2;
   localparam phase_type PH_OPP_REV    = 4'd3;
   localparam phase_type PH_ABD_APPR   = 4'd4;
   localparam phase_type PH_OPP_APPR   = 4'd5;
   localparam phase_type PH_OPP_TGT    = 4'd6;
   localparam phase_type PH_ABD_TGT    = 4'd7;
   localparam phase_type PH_FLEX_TGT   = 4'd8;
   localparam phase_type PH_COMPLETE   = 4'd9;
   localparam phase_type PH_ERROR      = 4'd10;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_RESET  = 2'd2;
   localparam logic [1:0] OP_TABLE  = 2'd3;

   localparam logic [2:0] F_FLEX_HOME   = 3'd0;
   localparam logic [2:0] F_FLEX_CLOSED = 3'd1;
   localparam logic [2:0] F_ABD_POS     = 3'd2;
   localparam logic [2:0] F_OPP_POS     = 3'd3;
   localparam logic [2:0] F_ABD_START   = 3'd4;
   localparam logic [2:0] F_OPP_START   = 3'd5;
   localparam logic [2:0] F_ABD_DIR     = 3'd6;
   localparam logic [2:0] F_OPP_DIR     = 3'd7;

   localparam logic [3:0] SEL_OPP_REV = 4'd8;
   localparam logic [3:0] SEL_ABD_REV = 4'd9;

   localparam logic [1:0] AX_FLEX = 2'd0;
   localparam logic [1:0] AX_ABD  = 2'd1;
   localparam logic [1:0] AX_OPP  = 2'd2;

   localparam logic [CsrIdxBits-1:0] CSR_POS_TOL   = 3'd0;
   localparam logic [CsrIdxBits-1:0] CSR_APPR_TOL  = 3'd1;
   localparam logic [CsrIdxBits-1:0] CSR_TIMEOUT   = 3'd2;
   localparam logic [CsrIdxBits-1:0] CSR_CLEARANCE = 3'd3;
   localparam logic [CsrIdxBits-1:0] CSR_POSE_CNT  = 3'd4;

   // One pose: eight 16-bit words, indexed by the field codes above.
   typedef logic [PoseFields-1:0][PosBits-1:0] pose_row_type;

endpackage

`default_nettype wire

### sv/tmps_req_if.sv
// Request channel of the thumb motion phase sequencer: valid/ready and payload.
// Depends on tmps_pkg.
`default_nettype none

interface tmps_req_if;
   import tmps_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                opcode;
   logic signed [PosBits-1:0] flex_now;
   logic signed [PosBits-1:0] abduction_now;
   logic signed [PosBits-1:0] opposition_now;
   logic [2:0]                src_pose;
   logic [2:0]                dst_pose;
   logic [FracBits-1:0]       flex_fraction;
   logic [3:0]                table_select;
   logic [5:0]                table_index;
   logic signed [PosBits-1:0] table_value;

   modport source (
      output valid, opcode, flex_now, abduction_now, opposition_now, src_pose,
             dst_pose, flex_fraction, table_select, table_index, table_value,
      input  ready
   );
   modport sink (
      input  valid, opcode, flex_now, abduction_now, opposition_now, src_pose,
             dst_pose, flex_fraction, table_select, table_index, table_value,
      output ready
   );
endinterface

`default_nettype wire

### sv/tmps_rsp_if.sv
// Response channel of the thumb motion phase sequencer: valid/ready and payload.
// Depends on tmps_pkg.
`default_nettype none

interface tmps_rsp_if;
   import tmps_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [3:0]                phase;
   logic                      changed;
   logic [1:0]                active_axis;
   logic signed [PosBits-1:0] target_position;
   logic                      rejected;
   logic                      timed_out;

   modport source (
      output valid, phase, changed, active_axis, target_position, rejected, timed_out,
      input  ready
   );
   modport sink (
      input  valid, phase, changed, active_axis, target_position, rejected, timed_out,
      output ready
   );
endinterface

`default_nettype wire

### sv/thumb_motion_phase_sequencer.sv
// Thumb motion phase sequencer.
//
// Requests arrive on req_chan (valid/ready). Each accepted transaction is one
// opcode: an update tick carrying the present axis positions, a start naming
// source and target poses, a return to idle, or a write of one pose or reversal
// table word. Every request yields exactly one response on rsp_chan, reporting
// the phase after the step, whether an update advanced or timed out the phase,
// the axis being driven and its target, and whether a start was rejected.
// Registers are written through csr_we/csr_index/csr_wdata.
//
// The response is valid in the cycle after its request is accepted. A new
// request can be taken every cycle while the receiver takes the responses; the
// single output register allows that rate, and req_chan.ready stays high while the
// output register is empty or being drained. If the receiver stalls, ready drops
// and the phase, pose and tick state holds until the response is taken.
//
// Reset returns the phase to idle, clears the pose indices, fraction and tick
// count and loads the register defaults. Pose and reversal tables are not
// cleared and must be written before use.
`default_nettype none

module thumb_motion_phase_sequencer (
   input  wire                                clock,
   input  wire                                reset,
   tmps_req_if.sink                           req_chan,
   tmps_rsp_if.source                         rsp_chan,
   input  wire                                csr_we,
   input  wire [tmps_pkg::CsrIdxBits-1:0]     csr_index,
   input  wire [tmps_pkg::CsrDataBits-1:0]    csr_wdata
);
   import tmps_pkg::*;

   // Registers and state
   logic [TolBits-1:0]          pos_tol_ff, appr_tol_ff;
   logic [TickBits-1:0]         timeout_ff;
   logic signed [PosBits-1:0]   clearance_ff;
   logic [3:0]                  pose_cnt_ff;

   phase_type                   phase_ff, phase_in;
   logic [PoseIdxBits-1:0]      from_ff, from_in, to_ff, to_in;
   logic [FracBits-1:0]         frac_ff, frac_in;
   logic [TickBits-1:0]         ticks_ff, ticks_in;

   pose_row_type                pose_ff [MaxPoses];
   pose_row_type                pose_in [MaxPoses];
   pose_row_type                from_row_ff, to_row_ff;

   logic signed [PosBits-1:0]   opp_rev_mem [RevDepth];
   logic signed [PosBits-1:0]   abd_rev_mem [RevDepth];
   logic signed [PosBits-1:0]   opp_rev_ff, abd_rev_ff;

   logic                        rsp_valid_ff;
   logic                        changed_ff, changed_in;
   logic                        rejected_ff, rejected_in;

   logic                        accept;
   logic [3:0]                  cnt_eff, cnt_next;
   logic [RevIdxBits-1:0]       rev_addr;
   logic                        wr_pose, wr_opp, wr_abd;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   function automatic logic [3:0] eff_count(input logic [3:0] c);
      if (c == 4'd0)
         return 4'd1;
      else if (c > 4'(MaxPoses))
         return 4'(MaxPoses);
      else
         return c;
   endfunction

   function automatic logic dir_matches(input logic signed [PosBits-1:0] s,
                                        input logic signed [PosBits-1:0] t,
                                        input logic signed [PosBits-1:0] d);
      return (s == t) || ((t > s) == (d > 0));
   endfunction

   assign cnt_eff = eff_count(pose_cnt_ff);

   // Route decisions for the current pose pair
   logic opp_rev, abd_rev, opp_appr, abd_appr;
   phase_type after_rev;

   assign opp_rev  = from_row_ff[F_OPP_DIR] != to_row_ff[F_OPP_DIR];
   assign abd_rev  = from_row_ff[F_ABD_DIR] != to_row_ff[F_ABD_DIR];
   assign opp_appr = !opp_rev && !dir_matches($signed(from_row_ff[F_OPP_POS]),
                        $signed(to_row_ff[F_OPP_POS]), $signed(to_row_ff[F_OPP_DIR]));
   assign abd_appr = !abd_rev && !dir_matches($signed(from_row_ff[F_ABD_POS]),
                        $signed(to_row_ff[F_ABD_POS]), $signed(to_row_ff[F_ABD_DIR]));
   assign after_rev = opp_appr ? PH_OPP_APPR : (abd_appr ? PH_ABD_APPR : PH_OPP_TGT);

   // Flex target: home plus fraction times span, rounded half away from zero.
   logic signed [PosBits:0]     span;
   logic signed [34:0]          prod, prod_abs, rnd;
   logic signed [PosBits-1:0]   flex_goal;

   assign span     = 17'($signed(to_row_ff[F_FLEX_CLOSED])) -
                     17'($signed(to_row_ff[F_FLEX_HOME]));
   assign prod     = $signed({18'd0, frac_ff}) * 35'(span);
   assign prod_abs = prod[34] ? -prod : prod;
   assign rnd      = prod[34] ? -((prod_abs + 35'sd32768) >>> 16)
                              :  ((prod_abs + 35'sd32768) >>> 16);
   assign flex_goal = $signed(to_row_ff[F_FLEX_HOME]) + rnd[PosBits-1:0];

   // Goal of the present phase
   logic [1:0]                axis;
   logic signed [PosBits-1:0] goal;

   always_comb begin
      case (phase_ff)
         PH_FLEX_CLEAR: begin axis = AX_FLEX; goal = clearance_ff; end
         PH_ABD_REV:    begin axis = AX_ABD;  goal = abd_rev_ff; end
         PH_OPP_REV:    begin axis = AX_OPP;  goal = opp_rev_ff; end
         PH_ABD_APPR:   begin axis = AX_ABD;  goal = $signed(to_row_ff[F_ABD_START]); end
         PH_OPP_APPR:   begin axis = AX_OPP;  goal = $signed(to_row_ff[F_OPP_START]); end
         PH_OPP_TGT:    begin axis = AX_OPP;  goal = $signed(to_row_ff[F_OPP_POS]); end
         PH_ABD_TGT:    begin axis = AX_ABD;  goal = $signed(to_row_ff[F_ABD_POS]); end
         PH_FLEX_TGT:   begin axis = AX_FLEX; goal = flex_goal; end
         default:       begin axis = AX_FLEX; goal = '0; end
      endcase
   end

   // Update tick evaluation
   logic signed [PosBits-1:0] now;
   logic signed [PosBits:0]   diff;
   logic [PosBits:0]          diff_abs;
   logic                      appr_phase, active, on_goal;
   logic [TickBits-1:0]       ticks_inc;
   phase_type                 next_ph;

   always_comb begin
      case (axis)
         AX_ABD:  now = req_chan.abduction_now;
         AX_OPP:  now = req_chan.opposition_now;
         default: now = req_chan.flex_now;
      endcase
   end

   assign diff       = 17'(now) - 17'(goal);
   assign diff_abs   = diff[PosBits] ? 17'(-diff) : 17'(diff);
   assign appr_phase = phase_ff inside {[PH_ABD_REV:PH_OPP_APPR]};
   assign active     = phase_ff inside {[PH_FLEX_CLEAR:PH_FLEX_TGT]};
   assign on_goal    = diff_abs <= {2'b00, (appr_phase ? appr_tol_ff : pos_tol_ff)};
   assign ticks_inc  = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;

   always_comb begin
      case (phase_ff)
         PH_FLEX_CLEAR: next_ph = abd_rev ? PH_ABD_REV : (opp_rev ? PH_OPP_REV : after_rev);
         PH_ABD_REV:    next_ph = opp_rev ? PH_OPP_REV : after_rev;
         PH_OPP_REV:    next_ph = after_rev;
         PH_OPP_APPR:   next_ph = abd_appr ? PH_ABD_APPR : PH_OPP_TGT;
         PH_ABD_APPR:   next_ph = PH_OPP_TGT;
         PH_OPP_TGT:    next_ph = PH_ABD_TGT;
         PH_ABD_TGT:    next_ph = PH_FLEX_TGT;
         PH_FLEX_TGT:   next_ph = PH_COMPLETE;
         default:       next_ph = phase_ff;
      endcase
   end

   // Next state for one transaction
   logic [FracBits-1:0] frac_sat;
   assign frac_sat = (req_chan.flex_fraction > 17'd65536) ? 17'd65536
                                                         : req_chan.flex_fraction;

   always_comb begin
      phase_in    = phase_ff;
      from_in     = from_ff;
      to_in       = to_ff;
      frac_in     = frac_ff;
      ticks_in    = ticks_ff;
      changed_in  = 1'b0;
      rejected_in = 1'b0;
      if (accept) begin
         case (req_chan.opcode)
            OP_UPDATE: begin
               if (active) begin
                  ticks_in = ticks_inc;
                  if (ticks_inc > timeout_ff) begin
                     phase_in   = PH_ERROR;
                     changed_in = 1'b1;
                  end else if (on_goal) begin
                     phase_in   = next_ph;
                     ticks_in   = '0;
                     changed_in = 1'b1;
                  end
               end
            end
            OP_START: begin
               if ({1'b0, req_chan.src_pose} >= cnt_eff ||
                   {1'b0, req_chan.dst_pose} >= cnt_eff) begin
                  rejected_in = 1'b1;
               end else begin
                  from_in  = req_chan.src_pose;
                  to_in    = req_chan.dst_pose;
                  frac_in  = frac_sat;
                  ticks_in = '0;
                  phase_in = (req_chan.src_pose == req_chan.dst_pose)
                             ? PH_FLEX_TGT : PH_FLEX_CLEAR;
               end
            end
            OP_RESET: begin
               phase_in = PH_IDLE;
               ticks_in = '0;
            end
            default: ;
         endcase
      end
   end

   // Table writes, with the new contents forwarded into the pose row copies
   assign wr_pose = accept && req_chan.opcode == OP_TABLE &&
                    !req_chan.table_select[3] && req_chan.table_index < 6'(MaxPoses);
   assign wr_opp  = accept && req_chan.opcode == OP_TABLE &&
                    req_chan.table_select == SEL_OPP_REV;
   assign wr_abd  = accept && req_chan.opcode == OP_TABLE &&
                    req_chan.table_select == SEL_ABD_REV;

   always_comb begin
      pose_in = pose_ff;
      if (wr_pose)
         pose_in[req_chan.table_index[PoseIdxBits-1:0]][req_chan.table_select[2:0]] =
            req_chan.table_value;
   end

   assign cnt_next = (csr_we && csr_index == CSR_POSE_CNT) ? eff_count(csr_wdata[3:0])
                                                          : cnt_eff;
   assign rev_addr = RevIdxBits'(from_in) * RevIdxBits'(cnt_next) + RevIdxBits'(to_in);

   always_ff @(posedge clock) begin
      pose_ff     <= pose_in;
      from_row_ff <= pose_in[from_in];
      to_row_ff   <= pose_in[to_in];
      if (wr_opp)
         opp_rev_mem[req_chan.table_index] <= req_chan.table_value;
      if (wr_abd)
         abd_rev_mem[req_chan.table_index] <= req_chan.table_value;
      opp_rev_ff <= (wr_opp && req_chan.table_index == rev_addr) ? req_chan.table_value
                                                                 : opp_rev_mem[rev_addr];
      abd_rev_ff <= (wr_abd && req_chan.table_index == rev_addr) ? req_chan.table_value
                                                                 : abd_rev_mem[rev_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_tol_ff   <= TolBits'(8);
         appr_tol_ff  <= TolBits'(32);
         timeout_ff   <= TickBits'(1000);
         clearance_ff <= '0;
         pose_cnt_ff  <= 4'd1;
         phase_ff     <= PH_IDLE;
         from_ff      <= '0;
         to_ff        <= '0;
         frac_ff      <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         changed_ff   <= 1'b0;
         rejected_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_POS_TOL:   pos_tol_ff   <= csr_wdata[TolBits-1:0];
               CSR_APPR_TOL:  appr_tol_ff  <= csr_wdata[TolBits-1:0];
               CSR_TIMEOUT:   timeout_ff   <= csr_wdata[TickBits-1:0];
               CSR_CLEARANCE: clearance_ff <= csr_wdata[PosBits-1:0];
               CSR_POSE_CNT:  pose_cnt_ff  <= csr_wdata[3:0];
               default: ;
            endcase
         end
         phase_ff <= phase_in;
         from_ff  <= from_in;
         to_ff    <= to_in;
         frac_ff  <= frac_in;
         ticks_ff <= ticks_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
            changed_ff   <= changed_in;
            rejected_ff  <= rejected_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // The response reports the state left by its transaction, which holds
   // until the response is taken.
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.phase           = phase_ff;
   assign rsp_chan.changed         = changed_ff;
   assign rsp_chan.active_axis     = axis;
   assign rsp_chan.target_position = goal;
   assign rsp_chan.rejected        = rejected_ff;
   assign rsp_chan.timed_out       = phase_ff == PH_ERROR;

   a_rejected_not_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rejected_ff |-> !changed_ff)
      else $error("rejected start reported a phase change");

   a_stall_holds_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> $stable(phase_ff) && $stable(ticks_ff))
      else $error("state moved while the response was stalled");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_ERROR)
      else $error("phase code out of range");

   a_changed_moves_phase: assert property (@(posedge clock) disable iff (reset)
      accept && changed_in |=> phase_ff != $past(phase_ff) && ticks_ff == '0 ||
                               phase_ff == PH_ERROR)
      else $error("phase change reported without a new phase");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the thumb motion phase sequencer. Drives requests,
// predicts each response with its own model of the phase sequence (a typed row
// carries its own) and compares. Depends on tmps_pkg, tmps_req_if and tmps_rsp_if.
`default_nettype none

module tb;
   import tmps_pkg::*;

   typedef struct {
      phase_type          phase;
      bit                 changed;
      logic [1:0]         axis;
      logic signed [15:0] target;
      bit                 rejected;
      bit                 timed_out;
   } status_type;

   typedef struct {
      logic [1:0]         opcode;
      logic signed [15:0] flex_now;
      logic signed [15:0] abd_now;
      logic signed [15:0] opp_now;
      logic [2:0]         src;
      logic [2:0]         tgt;
      logic [16:0]        frac;
      logic [3:0]         sel;
      logic [5:0]         idx;
      logic signed [15:0] val;
      bit                 typed;
      status_type         typed_status;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CsrIdxBits-1:0]  csr_index = '0;
   logic [CsrDataBits-1:0] csr_wdata = '0;

   tmps_req_if req_bus ();
   tmps_rsp_if rsp_bus ();

   thumb_motion_phase_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow state of the sequencer.
   logic signed [15:0] pose_words [MaxPoses][PoseFields];
   logic signed [15:0] opp_rev_words [RevDepth];
   logic signed [15:0] abd_rev_words [RevDepth];
   phase_type          seq_phase = PH_IDLE;
   int                 from_idx = 0;
   int                 to_idx = 0;
   logic [16:0]        closing_frac = '0;
   logic [23:0]        tick_count = '0;
   logic [14:0]        pos_tol = 15'd8;
   logic [14:0]        appr_tol = 15'd32;
   logic [23:0]        timeout_lim = 24'd1000;
   logic signed [15:0] clearance = '0;
   logic [3:0]         pose_cnt = 4'd1;

   status_type  expected_status_q [$];
   request_type cur_req;
   int          fail_count = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;
   int          stall_left = 0;

   function automatic int live_poses();
      if (pose_cnt < 1) return 1;
      if (pose_cnt > MaxPoses) return MaxPoses;
      return int'(pose_cnt);
   endfunction

   function automatic longint pw(int p, int f);
      return pose_words[p][f];
   endfunction

   function automatic bit dir_ok(longint s, longint t, longint d);
      if (s == t) return 1'b1;
      return (t > s) == (d > 0);
   endfunction

   function automatic bit opp_flips();
      return pw(from_idx, F_OPP_DIR) != pw(to_idx, F_OPP_DIR);
   endfunction

   function automatic bit abd_flips();
      return pw(from_idx, F_ABD_DIR) != pw(to_idx, F_ABD_DIR);
   endfunction

   function automatic bit opp_needs_lead_in();
      return !opp_flips() &&
             !dir_ok(pw(from_idx, F_OPP_POS), pw(to_idx, F_OPP_POS), pw(to_idx, F_OPP_DIR));
   endfunction

   function automatic bit abd_needs_lead_in();
      return !abd_flips() &&
             !dir_ok(pw(from_idx, F_ABD_POS), pw(to_idx, F_ABD_POS), pw(to_idx, F_ABD_DIR));
   endfunction

   function automatic longint flex_aim();
      longint home, span, prod, r;
      home = pw(to_idx, F_FLEX_HOME);
      span = pw(to_idx, F_FLEX_CLOSED) - home;
      prod = longint'(closing_frac) * span;
      if (prod >= 0) r = (prod + 32768) / 65536;
      else r = -((-prod + 32768) / 65536);
      return home + r;
   endfunction

   function automatic void phase_aim(phase_type ph, output logic [1:0] axis,
                                     output longint pos);
      int rev;
      rev = from_idx * live_poses() + to_idx;
      axis = AX_FLEX;
      pos = 0;
      case (ph)
         PH_FLEX_CLEAR: begin axis = AX_FLEX; pos = clearance; end
         PH_ABD_REV:    begin axis = AX_ABD;  pos = abd_rev_words[rev]; end
         PH_OPP_REV:    begin axis = AX_OPP;  pos = opp_rev_words[rev]; end
         PH_ABD_APPR:   begin axis = AX_ABD;  pos = pw(to_idx, F_ABD_START); end
         PH_OPP_APPR:   begin axis = AX_OPP;  pos = pw(to_idx, F_OPP_START); end
         PH_OPP_TGT:    begin axis = AX_OPP;  pos = pw(to_idx, F_OPP_POS); end
         PH_ABD_TGT:    begin axis = AX_ABD;  pos = pw(to_idx, F_ABD_POS); end
         PH_FLEX_TGT:   begin axis = AX_FLEX; pos = flex_aim(); end
         default: ;
      endcase
   endfunction

   function automatic phase_type after_flips();
      if (opp_needs_lead_in()) return PH_OPP_APPR;
      if (abd_needs_lead_in()) return PH_ABD_APPR;
      return PH_OPP_TGT;
   endfunction

   function automatic phase_type following_phase(phase_type ph);
      case (ph)
         PH_FLEX_CLEAR: begin
            if (abd_flips()) return PH_ABD_REV;
            if (opp_flips()) return PH_OPP_REV;
            return after_flips();
         end
         PH_ABD_REV:  return opp_flips() ? PH_OPP_REV : after_flips();
         PH_OPP_REV:  return after_flips();
         PH_OPP_APPR: return abd_needs_lead_in() ? PH_ABD_APPR : PH_OPP_TGT;
         PH_ABD_APPR: return PH_OPP_TGT;
         PH_OPP_TGT:  return PH_ABD_TGT;
         PH_ABD_TGT:  return PH_FLEX_TGT;
         PH_FLEX_TGT: return PH_COMPLETE;
         default:     return ph;
      endcase
   endfunction

   function automatic bit is_moving(phase_type ph);
      return ph >= PH_FLEX_CLEAR && ph <= PH_FLEX_TGT;
   endfunction

   function automatic status_type step_sequencer(request_type r);
      status_type s;
      logic [1:0] axis;
      longint pos, now, diff, tol;
      int src, tgt;
      logic [16:0] frac;
      s = '{default: '0};
      case (r.opcode)
         OP_UPDATE: if (is_moving(seq_phase)) begin
            if (tick_count != 24'hFFFFFF) tick_count++;
            if (tick_count > timeout_lim) begin
               seq_phase = PH_ERROR;
               s.changed = 1'b1;
            end else begin
               phase_aim(seq_phase, axis, pos);
               now = (axis == AX_FLEX) ? r.flex_now : (axis == AX_ABD) ? r.abd_now : r.opp_now;
               diff = now - pos;
               if (diff < 0) diff = -diff;
               tol = (seq_phase >= PH_ABD_REV && seq_phase <= PH_OPP_APPR) ? appr_tol : pos_tol;
               if (diff <= tol) begin
                  seq_phase = following_phase(seq_phase);
                  tick_count = '0;
                  s.changed = 1'b1;
               end
            end
         end
         OP_START: begin
            src = r.src;
            tgt = r.tgt;
            frac = (r.frac > 17'd65536) ? 17'd65536 : r.frac;
            if (src >= live_poses() || tgt >= live_poses()) begin
               s.rejected = 1'b1;
            end else begin
               from_idx = src;
               to_idx = tgt;
               closing_frac = frac;
               tick_count = '0;
               seq_phase = (src == tgt) ? PH_FLEX_TGT : PH_FLEX_CLEAR;
            end
         end
         OP_RESET: begin
            seq_phase = PH_IDLE;
            tick_count = '0;
         end
         default: begin
            if (r.sel < PoseFields) begin
               if (r.idx < MaxPoses) pose_words[r.idx[2:0]][r.sel[2:0]] = r.val;
            end else if (r.sel == SEL_OPP_REV) begin
               opp_rev_words[r.idx] = r.val;
            end else if (r.sel == SEL_ABD_REV) begin
               abd_rev_words[r.idx] = r.val;
            end
         end
      endcase
      phase_aim(seq_phase, axis, pos);
      s.phase = seq_phase;
      s.axis = axis;
      s.target = pos[15:0];
      s.timed_out = (seq_phase == PH_ERROR);
      return s;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Acceptance, prediction and comparison all happen on the rising edge.
   always @(posedge clock) begin
      status_type pred, got, want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            pred = step_sequencer(cur_req);
            expected_status_q.push_back(cur_req.typed ? cur_req.typed_status : pred);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.phase = rsp_bus.phase;
            got.changed = rsp_bus.changed;
            got.axis = rsp_bus.active_axis;
            got.target = rsp_bus.target_position;
            got.rejected = rsp_bus.rejected;
            got.timed_out = rsp_bus.timed_out;
            if (expected_status_q.size() == 0) begin
               $display("%0t: response with no transaction outstanding, phase %0d",
                        $time, got.phase);
               fail_count++;
            end else begin
               want = expected_status_q.pop_front();
               check_field("phase", want.phase, got.phase);
               check_field("changed", want.changed, got.changed);
               check_field("active_axis", want.axis, got.axis);
               check_field("target_position", want.target, got.target);
               check_field("rejected", want.rejected, got.rejected);
               check_field("timed_out", want.timed_out, got.timed_out);
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 5000) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, none once the run goes quiet.
   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   function automatic logic signed [15:0] any_word();
      logic [31:0] w;
      w = $urandom;
      return w[15:0];
   endfunction

   function automatic logic signed [15:0] any_direction();
      case ($urandom_range(0, 4))
         0: return -16'sd1;
         1: return 16'sd0;
         2: return 16'sd1;
         3: return 16'sd5;
         default: return any_word();
      endcase
   endfunction

   function automatic request_type blank_request();
      request_type r;
      r = '{default: '0};
      r.flex_now = any_word();
      r.abd_now = any_word();
      r.opp_now = any_word();
      r.src = 3'($urandom);
      r.tgt = 3'($urandom);
      r.frac = 17'($urandom);
      r.sel = 4'($urandom);
      r.idx = 6'($urandom);
      r.val = any_word();
      return r;
   endfunction

   function automatic request_type row(logic [1:0] op, logic signed [15:0] pos_all,
                                       int src, int tgt, int frac, int sel, int idx,
                                       bit typed, bit rej);
      request_type r;
      r = blank_request();
      r.opcode = op;
      r.flex_now = pos_all;
      r.abd_now = pos_all;
      r.opp_now = pos_all;
      r.src = 3'(src);
      r.tgt = 3'(tgt);
      r.frac = 17'(frac);
      r.sel = 4'(sel);
      r.idx = 6'(idx);
      r.typed = typed;
      r.typed_status.rejected = rej;
      return r;
   endfunction

   function automatic logic signed [15:0] near_goal(longint goal, longint tol);
      longint v;
      case ($urandom_range(0, 9))
         0: v = goal + tol;
         1: v = goal - tol;
         2: v = goal + tol + 1;
         3, 4, 5, 6, 7: v = goal + longint'($urandom_range(0, 2 * tol)) - tol;
         default: return any_word();
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic request_type next_request();
      request_type r;
      logic [1:0] axis;
      longint pos, tol;
      r = blank_request();
      if ($urandom_range(0, 3) == 0) begin
         // Noise: any opcode with raw content, directions mostly drawn from a small set.
         r.opcode = 2'($urandom);
         if (r.sel == F_ABD_DIR || r.sel == F_OPP_DIR) r.val = any_direction();
      end else if (is_moving(seq_phase)) begin
         r.opcode = OP_UPDATE;
         phase_aim(seq_phase, axis, pos);
         tol = (seq_phase >= PH_ABD_REV && seq_phase <= PH_OPP_APPR) ? appr_tol : pos_tol;
         if (axis == AX_FLEX) r.flex_now = near_goal(pos, tol);
         else if (axis == AX_ABD) r.abd_now = near_goal(pos, tol);
         else r.opp_now = near_goal(pos, tol);
      end else begin
         r.opcode = OP_START;
         r.src = 3'($urandom_range(0, live_poses() - 1));
         r.tgt = ($urandom_range(0, 5) == 0) ? r.src
                                             : 3'($urandom_range(0, live_poses() - 1));
         case ($urandom_range(0, 5))
            0: r.frac = 17'd0;
            1: r.frac = 17'd65536;
            2: r.frac = 17'h1FFFF;
            default: r.frac = 17'($urandom_range(0, 65536));
         endcase
      end
      return r;
   endfunction

   task automatic send(request_type r);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      cur_req = r;
      req_bus.opcode = r.opcode;
      req_bus.flex_now = r.flex_now;
      req_bus.abduction_now = r.abd_now;
      req_bus.opposition_now = r.opp_now;
      req_bus.src_pose = r.src;
      req_bus.dst_pose = r.tgt;
      req_bus.flex_fraction = r.frac;
      req_bus.table_select = r.sel;
      req_bus.table_index = r.idx;
      req_bus.table_value = r.val;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (expected_status_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(logic [CsrIdxBits-1:0] idx, longint data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data[CsrDataBits-1:0];
      case (idx)
         CSR_POS_TOL:   pos_tol = data[14:0];
         CSR_APPR_TOL:  appr_tol = data[14:0];
         CSR_TIMEOUT:   timeout_lim = data[23:0];
         CSR_CLEARANCE: clearance = data[15:0];
         CSR_POSE_CNT:  pose_cnt = data[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Register sets per random phase: tolerances, timeout, clearance, pose count.
   longint settings [6][5] = '{
      '{8, 32, 1000, 0, 8},
      '{0, 0, 1, -32768, 2},
      '{32767, 32767, 16777215, 32767, 15},
      '{100, 500, 0, 1234, 0},
      '{20, 60, 3, -500, 5},
      '{8, 32, 50, 0, 8}
   };

   request_type opening [12];

   initial begin
      request_type r;
      req_bus.valid = 1'b0;
      cur_req = blank_request();
      req_bus.opcode = OP_RESET;
      req_bus.flex_now = '0;
      req_bus.abduction_now = '0;
      req_bus.opposition_now = '0;
      req_bus.src_pose = '0;
      req_bus.dst_pose = '0;
      req_bus.flex_fraction = '0;
      req_bus.table_select = '0;
      req_bus.table_index = '0;
      req_bus.table_value = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Rows with a typed result come with a single pose in use, all but the last one while idle.
      opening[0]  = row(OP_UPDATE, 16'sh7FFF, 0, 0, 0, 0, 0, 1, 0);
      opening[1]  = row(OP_TABLE, 0, 0, 0, 0, 12, 5, 1, 0);
      opening[2]  = row(OP_TABLE, 0, 0, 0, 0, F_FLEX_HOME, 63, 1, 0);
      opening[3]  = row(OP_START, 0, 1, 0, 100, 0, 0, 1, 1);
      opening[4]  = row(OP_START, 0, 0, 7, 100, 0, 0, 1, 1);
      opening[5]  = row(OP_RESET, 0, 0, 0, 0, 0, 0, 1, 0);
      opening[6]  = row(OP_START, 0, 0, 0, 17'h1FFFF, 0, 0, 0, 0);
      opening[7]  = row(OP_UPDATE, -16'sh8000, 0, 0, 0, 0, 0, 0, 0);
      opening[8]  = row(OP_UPDATE, 16'sh7FFF, 0, 0, 0, 0, 0, 0, 0);
      opening[9]  = row(OP_RESET, 0, 0, 0, 0, 0, 0, 1, 0);
      opening[10] = row(OP_START, 0, 0, 0, 0, 0, 0, 0, 0);
      opening[11] = row(OP_UPDATE, 0, 0, 0, 0, 0, 0, 0, 0);
      for (int k = 0; k < 6; k++) send(opening[k]);

      // Fill every table word so that no unwritten entry is ever read.
      for (int p = 0; p < MaxPoses; p++)
         for (int f = 0; f < PoseFields; f++) begin
            r = row(OP_TABLE, 0, 0, 0, 0, f, p, 0, 0);
            r.val = (f == F_ABD_DIR || f == F_OPP_DIR) ? any_direction() : any_word();
            send(r);
         end
      for (int i = 0; i < RevDepth; i++) begin
         send(row(OP_TABLE, 0, 0, 0, 0, SEL_OPP_REV, i, 0, 0));
         send(row(OP_TABLE, 0, 0, 0, 0, SEL_ABD_REV, i, 0, 0));
      end
      for (int k = 6; k < 12; k++) send(opening[k]);
      drain();

      for (int s = 0; s < 6; s++) begin
         quiet = (s == 5);
         send(row(OP_RESET, 0, 0, 0, 0, 0, 0, 0, 0));
         drain();
         for (int k = 0; k < 5; k++) write_reg(k[CsrIdxBits-1:0], settings[s][k]);
         for (int n = 0; n < 165; n++) begin
            send(next_request());
            if (n == 100 && s == 2) drain();
         end
      end
      req_bus.valid = 1'b0;
      drain();
      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
sv/tmps_pkg.sv
sv/tmps_req_if.sv
sv/tmps_rsp_if.sv
sv/thumb_motion_phase_sequencer.sv
tb/tb.sv
